// ===== rtl/core/sbfd_pkg.sv =====
// Shared types, constants and helpers for the serial-bus frame decoder.
// Used by the frame store, the byte writer, the channel unpacker and the top level.
package sbfd_pkg;

  // Frame layout.
  localparam int unsigned FRAME_BYTES  = 25;
  localparam int unsigned FLAGS_AT     = 23;
  localparam int unsigned LAST_DATA    = 22;
  localparam int unsigned FIRST_DATA   = 1;
  localparam int unsigned NUM_CHANNELS = 16;
  localparam int unsigned CHAN_W       = 11;

  localparam logic [7:0] HEADER_BYTE = 8'h0F;
  localparam logic [7:0] FOOTER_BYTE = 8'h00;

  // Two frame buffers share one memory: one fills while the other drains.
  localparam int unsigned RAM_DEPTH = 2 * FRAME_BYTES;
  localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);
  localparam int unsigned POS_W     = $clog2(FRAME_BYTES);
  localparam int unsigned IDX_W     = $clog2(NUM_CHANNELS);

  // Bit gatherer: one byte may land on top of up to sixteen held bits.
  localparam int unsigned GATHER_W  = 24;
  localparam int unsigned COUNT_W   = $clog2(GATHER_W + 1);

  typedef logic [RAM_AW-1:0] ram_addr_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [IDX_W-1:0]  chan_idx_t;

  // Memory write port.
  typedef struct packed {
    logic      en;
    ram_addr_t addr;
    logic [7:0] data;
  } ram_wr_t;

  // Handoff of a completed frame from the writer to the unpacker.
  typedef struct packed {
    logic start;
    logic bank;
  } frame_hand_t;

  // Flat address of a byte position within one of the two frame buffers.
  function automatic ram_addr_t ram_addr(input logic bank, input pos_t pos);
    ram_addr_t base;
    base = bank ? RAM_AW'(FRAME_BYTES) : '0;
    return base + RAM_AW'(pos);
  endfunction

endpackage

// ===== rtl/core/sbfd_frame_ram.sv =====
// Frame store: one write port and one registered read port.
// Holds two frame buffers; depends on sbfd_pkg.
module sbfd_frame_ram (
  input  logic               clk,
  input  sbfd_pkg::ram_wr_t  wr,
  input  logic               rd_en,
  input  sbfd_pkg::ram_addr_t rd_addr,
  output logic [7:0]         rd_data
);
  import sbfd_pkg::*;

  logic [7:0] mem [RAM_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/sbfd_writer.sv =====
// Frame writer: header detection, byte position tracking and buffer selection.
// Writes every frame byte into the frame store; depends on sbfd_pkg.
module sbfd_writer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_byte,
  input  logic                   drain_busy,
  output sbfd_pkg::ram_wr_t      wr,
  output sbfd_pkg::frame_hand_t  hand
);
  import sbfd_pkg::*;

  pos_t       pos;
  logic [7:0] prior;
  logic       wr_bank;
  logic       accept;
  logic       at_footer;
  logic       hdr_ok;

  // The footer word is held off while the other buffer still drains, so a
  // completed frame never lands on a busy unpacker.
  assign at_footer = (pos == pos_t'(FRAME_BYTES - 1));
  assign in_ready  = !(at_footer && drain_busy);
  assign accept    = in_valid && in_ready;
  assign hdr_ok    = (in_byte == HEADER_BYTE) && (prior == FOOTER_BYTE);

  // Store a word whenever a frame is open or a valid header opens one.
  always_comb begin
    wr.en   = accept && ((pos != '0) || hdr_ok);
    wr.addr = ram_addr(wr_bank, pos);
    wr.data = in_byte;
  end

  // A good footer hands the filled buffer over.
  assign hand.start = accept && at_footer && (in_byte == FOOTER_BYTE);
  assign hand.bank  = wr_bank;

  // Position, previous word and buffer select.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      prior   <= FOOTER_BYTE;
      wr_bank <= 1'b0;
    end else if (accept) begin
      prior <= in_byte;
      if (pos == '0) begin
        if (hdr_ok) begin
          pos <= pos_t'(1);
        end
      end else if (!at_footer) begin
        pos <= pos + pos_t'(1);
      end else begin
        pos <= '0;
        if (in_byte == FOOTER_BYTE) begin
          wr_bank <= !wr_bank;
        end
      end
    end
  end

endmodule

// ===== rtl/core/sbfd_unpacker.sv =====
// Channel unpacker: reads a completed frame buffer byte by byte and slices
// eleven-bit channels from a bit gatherer. Depends on sbfd_pkg.
module sbfd_unpacker (
  input  logic                   clk,
  input  logic                   rst,
  input  sbfd_pkg::frame_hand_t  hand,
  output logic                   busy,
  output logic                   rd_en,
  output sbfd_pkg::ram_addr_t    rd_addr,
  input  logic [7:0]             rd_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sbfd_pkg::chan_idx_t    out_index,
  output logic [sbfd_pkg::CHAN_W-1:0] out_value,
  output logic [3:0]             out_flags,
  output logic                   out_last
);
  import sbfd_pkg::*;

  logic                bank;
  pos_t                rd_ptr;
  logic                rd_more;
  logic                rd_valid;
  logic                rd_flag;
  logic [GATHER_W-1:0] bits;
  logic [COUNT_W-1:0]  count;
  chan_idx_t           chan;
  logic [3:0]          flags;

  logic                emit;
  logic                arrive;
  logic [COUNT_W-1:0]  count_after;
  logic [COUNT_W-1:0]  count_next;
  logic [GATHER_W-1:0] bits_next;

  // A channel leaves once eleven bits are held and the output slot is free.
  assign emit   = busy && (count >= COUNT_W'(CHAN_W)) && (!out_valid || out_ready);
  assign arrive = rd_valid && !rd_flag;

  always_comb begin
    count_after = emit ? count - COUNT_W'(CHAN_W) : count;
    count_next  = arrive ? count_after + COUNT_W'(8) : count_after;
    bits_next   = emit ? (bits >> CHAN_W) : bits;
    if (arrive) begin
      bits_next = bits_next | (GATHER_W'(rd_data) << count_after);
    end
  end

  // Fetch the flags byte first, then the data bytes in order, only while
  // the gatherer has room for the word in flight.
  assign rd_en   = busy && rd_more && (count_next <= COUNT_W'(GATHER_W - 8));
  assign rd_addr = ram_addr(bank, rd_ptr);

  // Read sequencer and gatherer. The gatherer starts each frame empty, since
  // new bytes are merged in with an OR above the bits already held.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rd_more  <= 1'b0;
      rd_valid <= 1'b0;
      rd_flag  <= 1'b0;
      count    <= '0;
      bits     <= '0;
      chan     <= '0;
    end else if (hand.start) begin
      busy     <= 1'b1;
      bank     <= hand.bank;
      rd_ptr   <= pos_t'(FLAGS_AT);
      rd_more  <= 1'b1;
      rd_valid <= 1'b0;
      rd_flag  <= 1'b0;
      count    <= '0;
      bits     <= '0;
      chan     <= '0;
    end else begin
      rd_valid <= rd_en;
      rd_flag  <= rd_en && (rd_ptr == pos_t'(FLAGS_AT));
      count    <= count_next;
      bits     <= bits_next;
      if (rd_valid && rd_flag) begin
        flags <= rd_data[3:0];
      end
      if (rd_en) begin
        if (rd_ptr == pos_t'(FLAGS_AT)) begin
          rd_ptr <= pos_t'(FIRST_DATA);
        end else begin
          rd_ptr <= rd_ptr + pos_t'(1);
          if (rd_ptr == pos_t'(LAST_DATA)) begin
            rd_more <= 1'b0;
          end
        end
      end
      if (emit) begin
        chan <= chan + chan_idx_t'(1);
        if (chan == chan_idx_t'(NUM_CHANNELS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Output register; the next channel may load as the current one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_index <= chan;
      out_value <= bits[CHAN_W-1:0];
      out_flags <= flags;
      out_last  <= (chan == chan_idx_t'(NUM_CHANNELS - 1));
    end
  end

`ifndef NO_ASSERTIONS
  // The writer never hands over a frame while one is still draining.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    hand.start |-> !busy)
    else $error("frame handed over while unpacker busy");

  // The gatherer never holds more bits than it has room for.
  a_gather_room: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(GATHER_W))
    else $error("bit gatherer overflow");

  // The sixteenth channel ends the drain.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (emit && chan == chan_idx_t'(NUM_CHANNELS - 1) && !hand.start) |=> !busy)
    else $error("unpacker still busy after last channel");

  // No memory reads outside a drain.
  a_rd_in_drain: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !rd_en)
    else $error("frame store read while idle");
`endif

endmodule

// ===== rtl/core/sbus_frame_decoder.sv =====
// Top level of the serial-bus frame decoder: byte stream in, channel words out.
// Instantiates sbfd_writer, sbfd_frame_ram and sbfd_unpacker; depends on sbfd_pkg.
//
//   channel | direction | content
//   --------+-----------+------------------------------------------------------
//   s_*     | in        | one received byte per word
//   m_*     | out       | one channel per word, tlast on channel 15 of a frame
//
// Input words are taken one per cycle while s_tready is high. A frame's bytes fill one
// of two buffers in the frame store while the other buffer drains. A drain runs from the
// footer to the last channel entering the output register: 23 reads on the one read port,
// with a read held back whenever the gatherer has no room for another byte.
// Only the footer word of the next frame waits while a drain is still running;
// a stalled output holds one channel and pauses the drain.
// rst is synchronous and active high; the store needs no clearing after reset.
module sbus_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] channel_index, [14:4] channel_value,
                                 // [15] digital_ch17, [16] digital_ch18,
                                 // [17] frame_lost, [18] failsafe_active, zero fill
  output logic        m_tlast    // last
);
  import sbfd_pkg::*;

  ram_wr_t     wr;
  frame_hand_t hand;
  logic        busy;
  logic        rd_en;
  ram_addr_t   rd_addr;
  logic [7:0]  rd_data;
  chan_idx_t   out_index;
  logic [10:0] out_value;
  logic [3:0]  out_flags;

  sbfd_writer u_writer (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .drain_busy (busy),
    .wr         (wr),
    .hand       (hand)
  );

  sbfd_frame_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sbfd_unpacker u_unpacker (
    .clk       (clk),
    .rst       (rst),
    .hand      (hand),
    .busy      (busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_index (out_index),
    .out_value (out_value),
    .out_flags (out_flags),
    .out_last  (m_tlast)
  );

  // Pack the channel word.
  assign m_tdata = {5'b0, out_flags, out_value, out_index};

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for sbus_frame_decoder: byte words in, channel words out.
// A directed table of frames comes first, then random frames, bad frames and noise.
// Depends on sbfd_pkg and the sbus_frame_decoder top level.
module tb_top;
  import sbfd_pkg::*;

  // One expected channel word.
  typedef struct {
    logic [3:0]  idx;
    logic [10:0] value;
    logic        ch17;
    logic        ch18;
    logic        lost;
    logic        failsafe;
    logic        last;
  } chan_word_t;

  // One row of the directed table. Data bytes 1 to 22 are fill + step * (i - 1).
  typedef enum logic {ROW_PREDICT, ROW_TYPED} row_kind_t;
  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  n_lead;
    logic [7:0]  lead0;
    logic [7:0]  lead1;
    logic [7:0]  fill;
    logic [7:0]  step;
    logic [7:0]  flags;
    logic [7:0]  footer;
    logic [10:0] want_value;
    logic [3:0]  want_flags;
  } frame_row_t;

  localparam int NUM_ROWS  = 7;
  localparam int NUM_ITEMS = 230;
  localparam int IDLE_PCT  = 17;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;

  // Decoder copy kept by the testbench.
  logic [7:0]  rx_copy [FRAME_BYTES];
  int          frame_pos;
  logic [7:0]  prev_byte;
  bit          frame_done;
  chan_word_t  decoded [NUM_CHANNELS];

  chan_word_t  pending_chans [$];
  logic [7:0]  frame_buf [FRAME_BYTES];
  frame_row_t  dir_rows [NUM_ROWS];
  bit          idle_on = 1'b1;
  int          mismatch_count = 0;
  int          words_checked = 0;
  int          frames_decoded = 0;
  int          bytes_sent = 0;

  sbus_frame_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Clock with a period of 12.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("tb_top: mismatch on %s: got %0d, want %0d, after %0d words",
             what, got, want, words_checked);
    mismatch_count++;
  endtask

  // Advances the decoder copy by one accepted byte and fills decoded[] on a good frame.
  function automatic void decode_byte(input logic [7:0] b);
    int          bitpos;
    int          base;
    logic [23:0] window;
    logic [7:0]  fl;
    frame_done = 1'b0;
    if (frame_pos == 0) begin
      if (b == HEADER_BYTE && prev_byte == FOOTER_BYTE) begin
        rx_copy[0] = b;
        frame_pos = 1;
      end
    end else begin
      rx_copy[frame_pos] = b;
      if (frame_pos < FRAME_BYTES - 1) begin
        frame_pos++;
      end else begin
        frame_pos = 0;
        frame_done = (b == FOOTER_BYTE);
      end
    end
    prev_byte = b;
    if (frame_done) begin
      frames_decoded++;
      fl = rx_copy[FLAGS_AT];
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        // Channel k spans bits 11k to 11k+10 of the data bytes, least significant first.
        bitpos = CHAN_W * k;
        base = FIRST_DATA + (bitpos >> 3);
        window = {rx_copy[base + 2], rx_copy[base + 1], rx_copy[base]};
        decoded[k].idx      = 4'(k);
        decoded[k].value    = 11'(window >> (bitpos & 7));
        decoded[k].ch17     = fl[0];
        decoded[k].ch18     = fl[1];
        decoded[k].lost     = fl[2];
        decoded[k].failsafe = fl[3];
        decoded[k].last     = (k == NUM_CHANNELS - 1);
      end
    end
  endfunction

  // Sends one byte word with a random gap in front; returns at the accepting edge.
  task automatic send_byte(input logic [7:0] b, input bit push_pred);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    decode_byte(b);
    if (push_pred && frame_done) begin
      for (int k = 0; k < NUM_CHANNELS; k++) pending_chans.push_back(decoded[k]);
    end
  endtask

  // Sends frame_buf; typed frames queue the values given instead of the predicted ones.
  task automatic send_frame(input bit typed, input logic [10:0] tval, input logic [3:0] tflags);
    chan_word_t w;
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(frame_buf[i], !typed);
    if (typed && frame_done) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        w.idx      = 4'(k);
        w.value    = tval;
        w.ch17     = tflags[0];
        w.ch18     = tflags[1];
        w.lost     = tflags[2];
        w.failsafe = tflags[3];
        w.last     = (k == NUM_CHANNELS - 1);
        pending_chans.push_back(w);
      end
    end
  endtask

  // Random output stalls, switched off along with input gaps during the quiet stretch.
  always @(negedge clk) begin
    m_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
  end

  // Output checker: each accepted channel word against the oldest expectation.
  always @(posedge clk) begin : check_out
    chan_word_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_chans.size() == 0) begin
        report_mismatch("unexpected channel word", int'(m_tdata), -1);
      end else begin
        w = pending_chans.pop_front();
        if (m_tdata[3:0] !== w.idx) begin
          report_mismatch("channel_index", int'(m_tdata[3:0]), int'(w.idx));
        end
        if (m_tdata[14:4] !== w.value) begin
          report_mismatch("channel_value", int'(m_tdata[14:4]), int'(w.value));
        end
        if (m_tdata[15] !== w.ch17) begin
          report_mismatch("digital_ch17", int'(m_tdata[15]), int'(w.ch17));
        end
        if (m_tdata[16] !== w.ch18) begin
          report_mismatch("digital_ch18", int'(m_tdata[16]), int'(w.ch18));
        end
        if (m_tdata[17] !== w.lost) begin
          report_mismatch("frame_lost", int'(m_tdata[17]), int'(w.lost));
        end
        if (m_tdata[18] !== w.failsafe) begin
          report_mismatch("failsafe_active", int'(m_tdata[18]), int'(w.failsafe));
        end
        if (m_tdata[23:19] !== 5'd0) report_mismatch("zero fill", int'(m_tdata[23:19]), 0);
        if (m_tlast !== w.last) report_mismatch("tlast", int'(m_tlast), int'(w.last));
        words_checked++;
      end
    end
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #(12 * 400000);
    $display("tb_top: timeout with %0d channel words outstanding", pending_chans.size());
    $display("tb_top: done, errors");
    $finish;
  end

  // Stimulus.
  initial begin : stimulus
    frame_row_t r;
    int         choice;
    int         n;
    int         rand_frames;
    int         wait_cycles;
    logic [7:0] b;

    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    for (int i = 0; i < FRAME_BYTES; i++) rx_copy[i] = 8'h00;
    frame_pos = 0;
    prev_byte = FOOTER_BYTE;

    // Directed frames. Typed rows carry their expected channel value and flag nibble.
    //                kind         lead   lead0  lead1  fill   step   flags  footer val      flg
    // Header right after reset, all data ones, upper flag bits set and ignored.
    dir_rows[0] = '{ROW_TYPED,   2'd0, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 11'h7FF, 4'hF};
    // Header right after a footer, all zero data and flags.
    dir_rows[1] = '{ROW_TYPED,   2'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 11'h000, 4'h0};
    // Header value used as data inside a frame.
    dir_rows[2] = '{ROW_PREDICT, 2'd0, 8'h00, 8'h00, 8'h0F, 8'h00, 8'h05, 8'h00, 11'h000, 4'h0};
    // Bad footer: the frame is dropped.
    dir_rows[3] = '{ROW_TYPED,   2'd0, 8'h00, 8'h00, 8'h55, 8'h00, 8'h0A, 8'h01, 11'h000, 4'h0};
    // Header without a zero in front is ignored, then a zero lets the next one start.
    dir_rows[4] = '{ROW_PREDICT, 2'd2, 8'h0F, 8'h00, 8'h01, 8'h13, 8'h03, 8'h00, 11'h000, 4'h0};
    // Footer of all ones is bad as well.
    dir_rows[5] = '{ROW_TYPED,   2'd0, 8'h00, 8'h00, 8'hA5, 8'h11, 8'h0C, 8'hFF, 11'h000, 4'h0};
    // Zero after a bad footer, then a frame with varied channels.
    dir_rows[6] = '{ROW_PREDICT, 2'd1, 8'h00, 8'h00, 8'h80, 8'h25, 8'hF6, 8'h00, 11'h000, 4'h0};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table.
    for (int row = 0; row < NUM_ROWS; row++) begin
      r = dir_rows[row];
      if (r.n_lead > 0) send_byte(r.lead0, 1'b1);
      if (r.n_lead > 1) send_byte(r.lead1, 1'b1);
      frame_buf[0] = HEADER_BYTE;
      for (int i = FIRST_DATA; i <= LAST_DATA; i++) frame_buf[i] = 8'(r.fill + r.step * (i - 1));
      frame_buf[FLAGS_AT] = r.flags;
      frame_buf[FRAME_BYTES - 1] = r.footer;
      send_frame(r.kind == ROW_TYPED, r.want_value, r.want_flags);
    end

    // Hold the sender until every expected channel word has come out.
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_chans.size() != 0) @(posedge clk);

    // Random part: mostly well-formed frames with random content, some bad footers and noise.
    rand_frames = 0;
    while (bytes_sent < NUM_ITEMS) begin
      // The first two random frames run with no gaps on either side.
      idle_on = (rand_frames >= 2);
      // Let a frame started by noise run out first.
      while (frame_pos != 0) send_byte(8'($urandom_range(255)), 1'b1);
      choice = $urandom_range(99);
      if (choice < 15) begin
        // Noise, rich in header and footer values.
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(9))
            0, 1, 2: b = HEADER_BYTE;
            3, 4:    b = FOOTER_BYTE;
            default: b = 8'($urandom_range(255));
          endcase
          send_byte(b, 1'b1);
        end
      end else begin
        if (prev_byte != FOOTER_BYTE) begin
          if ($urandom_range(2) == 0) send_byte(HEADER_BYTE, 1'b1);
          send_byte(FOOTER_BYTE, 1'b1);
        end
        frame_buf[0] = HEADER_BYTE;
        for (int i = FIRST_DATA; i < FRAME_BYTES - 1; i++) begin
          case ($urandom_range(19))
            0, 1:    frame_buf[i] = 8'h00;
            2, 3:    frame_buf[i] = 8'hFF;
            4:       frame_buf[i] = HEADER_BYTE;
            default: frame_buf[i] = 8'($urandom_range(255));
          endcase
        end
        frame_buf[FRAME_BYTES - 1] = (choice < 30) ? 8'($urandom_range(255, 1)) : FOOTER_BYTE;
        send_frame(1'b0, 11'h000, 4'h0);
        rand_frames++;
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    idle_on = 1'b1;

    // Drain, then watch a little longer for stray words.
    wait_cycles = 0;
    while (pending_chans.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (60) @(posedge clk);
    if (pending_chans.size() != 0) begin
      report_mismatch("channel words never produced", pending_chans.size(), 0);
    end

    $display("tb_top: %0d bytes sent in %0d random frames plus noise and a directed table,",
             bytes_sent, rand_frames);
    $display("tb_top: %0d frames decoded and %0d channel words checked",
             frames_decoded, words_checked);
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
